// ===== rtl/core/at_response_classifier_assert.svh =====
// Assertion macros shared by the classifier checks.
`ifndef AT_RESPONSE_CLASSIFIER_ASSERT_SVH
`define AT_RESPONSE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define ARC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("at_response_classifier check failed");

// Next-cycle implication.
`define ARC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("at_response_classifier check failed");

`endif

// ===== rtl/core/arc_pkg.sv =====
package arc_pkg;

   localparam int unsigned NumPrefixes = 30;
   localparam int unsigned MaxLen      = 20;
   localparam int unsigned PosW        = 5;
   localparam int unsigned CodeW       = 5;

   localparam logic [CodeW-1:0] CODE_UNKNOWN     = 5'd28;
   localparam logic [CodeW-1:0] CODE_PARSE_ERROR = 5'd29;

   // Prefix text, right-justified; first character in the top occupied byte.
   // \015 is carriage return.
   localparam logic [MaxLen*8-1:0] PREFIX_TEXT [NumPrefixes] = '{
      "^BOOT:",
      "OK\015",
      "^RSSI:",
      "^MODE:",
      "^CEND:",
      "+CSSI:",
      "^ORIG:",
      "^CONF:",
      "^CONN:",
      "+CREG:",
      "+COPS:",
      "^SRVST:",
      "+CSQ:",
      "+CPIN:",
      "RING\015",
      "+CLIP:",
      "ERROR\015",
      "+CMTI:",
      "+CMGR:",
      "+CSSU:",
      "BUSY\015",
      "NO DIALTONE\015",
      "NO CARRIER\015",
      "COMMAND NOT SUPPORT\015",
      "+CMS ERROR:",
      "^SMMEMFULL:",
      "> ",
      "+CUSD:",
      "+CNUM:",
      "ERROR+CNUM:"
   };

   localparam logic [PosW-1:0] PREFIX_LEN [NumPrefixes] = '{
      5'd6,  5'd3,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
      5'd6,  5'd7,  5'd5,  5'd6,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
      5'd5,  5'd12, 5'd11, 5'd20, 5'd11, 5'd11, 5'd2,  5'd6,  5'd6,  5'd11
   };

   // Command-not-supported reports the error kind, ERROR+CNUM: the number kind.
   localparam logic [CodeW-1:0] PREFIX_CODE [NumPrefixes] = '{
      5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd16, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd27
   };

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
      logic       record_present;
   } req_item_type;

   typedef struct packed {
      logic             emit;
      logic [CodeW-1:0] code;
   } match_result_type;

endpackage

// ===== rtl/core/at_response_classifier.sv =====
// AT response prefix classifier. Bytes of one modem response record arrive
// one per transfer on the req_ channel, the final byte marked by
// req_last_byte. Each byte is checked against 30 fixed prefixes; on the final
// byte one class code goes out on the rsp_ channel: the first prefix in
// priority order that matched in full (0..27), 28 when none did. A transfer
// with req_record_present low yields code 29 at once and drops any partly
// received record. Bytes that do not end a record produce no response.
// Throughput is one byte per clock while no waiting result blocks the input.
// Each result passes the input register, which holds its byte, and then the
// result register, into which its code is loaded and which drives rsp_valid.
// The input keeps flowing while a result waits on rsp_stall until that
// waiting result blocks the next result-producing byte. LONGEST_PREFIX
// caps the tracked byte position; prefixes longer than it never match.
module at_response_classifier #(
   parameter int unsigned LONGEST_PREFIX = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_byte_in,
   input  logic                      req_last_byte,
   input  logic                      req_record_present,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [arc_pkg::CodeW-1:0] rsp_class_code
);

   arc_pkg::req_item_type     item;
   arc_pkg::match_result_type result;
   logic                      item_valid;
   logic                      out_free;
   logic                      advance;

   // A byte leaves the input register when it needs no response slot, or
   // when the result register is empty or draining this cycle.
   assign advance = item_valid && (!result.emit || out_free);

   arc_in_stage u_in (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .req_last_byte      (req_last_byte),
      .req_record_present (req_record_present),
      .advance            (advance),
      .item_valid         (item_valid),
      .item               (item)
   );

   // Live bits and byte position; updated only as bytes leave the input reg.
   arc_matcher #(
      .LONGEST_PREFIX (LONGEST_PREFIX)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   arc_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && result.emit),
      .code           (result.code),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_class_code (rsp_class_code)
   );

endmodule

// ===== rtl/core/arc_in_stage.sv =====
module arc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_last_byte,
   input  logic                  req_record_present,
   input  logic                  advance,
   output logic                  item_valid,
   output arc_pkg::req_item_type item
);

   logic                  valid_ff, valid_in;
   arc_pkg::req_item_type item_ff;
   logic                  take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{byte_in: req_byte_in, last_byte: req_last_byte,
                      record_present: req_record_present};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/arc_matcher.sv =====
module arc_matcher #(
   parameter int unsigned LONGEST_PREFIX = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  arc_pkg::req_item_type     item,
   output arc_pkg::match_result_type result
);

   localparam logic [arc_pkg::PosW-1:0] LpPos = arc_pkg::PosW'(LONGEST_PREFIX);

   logic [arc_pkg::NumPrefixes-1:0] alive_ff, alive_in, alive_nxt, hit;
   logic [arc_pkg::PosW-1:0]        pos_ff, pos_in, pos_nxt;
   logic [arc_pkg::CodeW-1:0]       first_code;

   assign pos_nxt = (pos_ff >= LpPos) ? LpPos : pos_ff + 1'b1;

   for (genvar i = 0; i < arc_pkg::NumPrefixes; i++) begin : g_pfx
      logic [arc_pkg::PosW-1:0] off;
      logic [7:0]               exp_char;
      logic                     kill;

      // offset of the current character from the right end of the text
      assign off      = arc_pkg::PREFIX_LEN[i] - 5'd1 - pos_ff;
      assign exp_char = 8'(arc_pkg::PREFIX_TEXT[i] >> {off, 3'b000});
      assign kill     = (arc_pkg::PREFIX_LEN[i] > LpPos) ||
                        ((pos_ff < arc_pkg::PREFIX_LEN[i]) && (exp_char != item.byte_in));
      assign alive_nxt[i] = alive_ff[i] && !kill;
      assign hit[i]       = alive_nxt[i] && (pos_nxt >= arc_pkg::PREFIX_LEN[i]);
   end

   // lowest index wins
   always_comb begin
      first_code = arc_pkg::CODE_UNKNOWN;
      for (int i = arc_pkg::NumPrefixes - 1; i >= 0; i--) begin
         if (hit[i]) begin
            first_code = arc_pkg::PREFIX_CODE[i];
         end
      end
   end

   always_comb begin
      result.emit = !item.record_present || item.last_byte;
      result.code = item.record_present ? first_code : arc_pkg::CODE_PARSE_ERROR;
   end

   always_comb begin
      alive_in = alive_ff;
      pos_in   = pos_ff;
      if (advance) begin
         if (result.emit) begin
            alive_in = '1;
            pos_in   = '0;
         end else begin
            alive_in = alive_nxt;
            pos_in   = pos_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '1;
         pos_ff   <= '0;
      end else begin
         alive_ff <= alive_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ===== rtl/core/arc_out_stage.sv =====
module arc_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [arc_pkg::CodeW-1:0]  code,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [arc_pkg::CodeW-1:0]  rsp_class_code
);

   logic                      valid_ff, valid_in;
   logic [arc_pkg::CodeW-1:0] code_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_class_code = code_ff;

endmodule

// ===== rtl/core/arc_checker.sv =====
`include "at_response_classifier_assert.svh"

module arc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [arc_pkg::CodeW-1:0] rsp_class_code
);

   `ARC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_class_code))
   `ARC_ASSERT_IMP(a_code_range, clock, reset, rsp_valid,
                   rsp_class_code <= arc_pkg::CODE_PARSE_ERROR)
   `ARC_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `ARC_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ARC_ASSERT_NXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid)

endmodule

bind at_response_classifier arc_checker u_checker (.*);

// ===== tb/at_response_classifier_test.sv =====
`timescale 1ns / 100ps

module at_response_classifier_test;

   // Tracked byte position limit handed to the block; the predictor uses the same value.
   localparam int unsigned TRACK_LIMIT    = 20;
   // Input transfers in the whole run, directed part included; the random part stops once reached.
   localparam int          ITEM_TARGET    = 2000;
   // Final stretch of the run with no idling on either side.
   localparam int          QUIET_TAIL     = 300;
   // Cycles with no transfer on either channel before the run is abandoned.
   localparam int          WATCHDOG_LIMIT = 2000;
   // Mismatches printed in full; later ones are only counted.
   localparam int          REPORT_LIMIT   = 10;

   // Response kinds, in the order of the block's class codes.
   typedef enum logic [arc_pkg::CodeW-1:0] {
      KIND_BOOT, KIND_OK, KIND_RSSI, KIND_MODE, KIND_CEND, KIND_CSSI, KIND_ORIG,
      KIND_CONF, KIND_CONN, KIND_CREG, KIND_COPS, KIND_SRVST, KIND_CSQ, KIND_CPIN,
      KIND_RING, KIND_CLIP, KIND_ERROR, KIND_CMTI, KIND_CMGR, KIND_CSSU, KIND_BUSY,
      KIND_NO_DIALTONE, KIND_NO_CARRIER, KIND_CMS_ERROR, KIND_SMMEMFULL,
      KIND_SMS_PROMPT, KIND_CUSD, KIND_CNUM, KIND_UNKNOWN, KIND_PARSE_ERROR
   } response_kind_type;

   // Tracks the record being received, works out the class code that each
   // final byte (or no-record transfer) yields, and checks the codes that come back.
   class record_class_tracker;
      string             text [30];
      response_kind_type kind [30];
      logic [29:0]       alive;
      logic [4:0]        position;
      response_kind_type expected_codes [$];
      int                failures;

      function new();
         // Priority order; \015 is carriage return.
         text = '{"^BOOT:", "OK\015", "^RSSI:", "^MODE:", "^CEND:", "+CSSI:",
                  "^ORIG:", "^CONF:", "^CONN:", "+CREG:", "+COPS:", "^SRVST:",
                  "+CSQ:", "+CPIN:", "RING\015", "+CLIP:", "ERROR\015", "+CMTI:",
                  "+CMGR:", "+CSSU:", "BUSY\015", "NO DIALTONE\015",
                  "NO CARRIER\015", "COMMAND NOT SUPPORT\015", "+CMS ERROR:",
                  "^SMMEMFULL:", "> ", "+CUSD:", "+CNUM:", "ERROR+CNUM:"};
         // Command-not-supported reports the error kind, ERROR+CNUM: the number kind.
         kind = '{KIND_BOOT, KIND_OK, KIND_RSSI, KIND_MODE, KIND_CEND, KIND_CSSI,
                  KIND_ORIG, KIND_CONF, KIND_CONN, KIND_CREG, KIND_COPS, KIND_SRVST,
                  KIND_CSQ, KIND_CPIN, KIND_RING, KIND_CLIP, KIND_ERROR, KIND_CMTI,
                  KIND_CMGR, KIND_CSSU, KIND_BUSY, KIND_NO_DIALTONE,
                  KIND_NO_CARRIER, KIND_ERROR, KIND_CMS_ERROR, KIND_SMMEMFULL,
                  KIND_SMS_PROMPT, KIND_CUSD, KIND_CNUM, KIND_CNUM};
         alive    = '1;
         position = '0;
         failures = 0;
      endfunction

      // One accepted input transfer.
      function void take_item(logic [7:0] data, logic last, logic present);
         logic [29:0]       next_alive;
         int                next_pos;
         response_kind_type code;
         if (!present) begin
            alive    = '1;
            position = '0;
            expected_codes.push_back(KIND_PARSE_ERROR);
            return;
         end
         next_alive = alive;
         for (int i = 0; i < 30; i++) begin
            if (text[i].len() > TRACK_LIMIT)
               next_alive[i] = 1'b0;
            else if (position < text[i].len() && text[i][position] != data)
               next_alive[i] = 1'b0;
         end
         next_pos = position + 1;
         if (next_pos > TRACK_LIMIT)
            next_pos = TRACK_LIMIT;
         if (!last) begin
            alive    = next_alive;
            position = 5'(next_pos);
            return;
         end
         code = KIND_UNKNOWN;
         for (int i = 29; i >= 0; i--)
            if (next_alive[i] && next_pos >= text[i].len())
               code = kind[i];
         alive    = '1;
         position = '0;
         expected_codes.push_back(code);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      // One accepted result transfer.
      function void check_code(logic [arc_pkg::CodeW-1:0] got);
         response_kind_type want;
         if (expected_codes.size() == 0) begin
            note_failure($sformatf("class_code %0d with nothing expected", got));
            return;
         end
         want = expected_codes.pop_front();
         if (got !== want)
            note_failure($sformatf("class_code expected %0d (%s) actual %0d",
                                   want, want.name(), got));
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction
   endclass

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic                      req_valid          = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_byte_in        = 8'h00;
   logic                      req_last_byte      = 1'b0;
   logic                      req_record_present = 1'b1;
   logic                      rsp_valid;
   logic                      rsp_stall          = 1'b0;
   logic [arc_pkg::CodeW-1:0] rsp_class_code;

   record_class_tracker tracker = new();

   int   items_sent = 0;
   logic no_idle    = 1'b0;   // final stretch: both sides stop idling
   logic calm_tx    = 1'b0;   // sender stretch with no gaps
   logic calm_rx    = 1'b0;   // receiver stretch with no stalls

   wire req_xfer = req_valid && !req_stall;
   wire rsp_xfer = rsp_valid && !rsp_stall;

   at_response_classifier #(
      .LONGEST_PREFIX(TRACK_LIMIT)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_last_byte     (req_last_byte),
      .req_record_present(req_record_present),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_class_code    (rsp_class_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive one byte transfer. Called at a falling edge, returns at a falling
   // edge. Valid stays high into the next transfer unless a gap is taken, so
   // it is never dropped and raised within one time step.
   task automatic send_item(input logic [7:0] data, input logic last, input logic present);
      req_valid          <= 1'b1;
      req_byte_in        <= data;
      req_last_byte      <= last;
      req_record_present <= present;
      // Stall is sampled with its pre-edge value.
      do @(posedge clock); while (req_stall);
      tracker.take_item(data, last, present);
      items_sent++;
      no_idle = (items_sent >= ITEM_TARGET - QUIET_TAIL);
      if ($urandom_range(0, 149) == 0)
         calm_tx = !calm_tx;
      @(negedge clock);
      // Sender gap burst with valid low.
      if (!no_idle && !calm_tx && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Send a whole record from a string, final byte marked.
   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++)
         send_item(s[k], k == s.len() - 1, 1'b1);
   endtask

   // Send a record from a byte queue; when abort_at is a valid index, a
   // no-record transfer goes in ahead of that byte and drops what came before.
   task automatic send_bytes(input bit [7:0] body [$], input int abort_at);
      for (int k = 0; k < body.size(); k++) begin
         if (k == abort_at)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
         send_item(body[k], k == body.size() - 1, 1'b1);
      end
   endtask

   // Receiver: stall bursts driven at the falling edge; calm stretches and the
   // final stretch start no new bursts.
   initial begin : stall_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0)
            calm_rx = !calm_rx;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!no_idle && !calm_rx && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result monitor: every accepted code is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_xfer)
         tracker.check_code(rsp_class_code);
   end

   // Watchdog: a run that moves nothing on either channel for too long is dead.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (req_xfer || rsp_xfer)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      bit [7:0] body [$];
      int       pick;
      int       idx;
      int       n;
      int       tail_len;
      int       abort_at;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part.
      // No-record transfer while idle.
      send_item(8'h00, 1'b0, 1'b0);
      // Shortest prefix, the SMS prompt.
      send_text("> ");
      // One-byte record of all ones: unknown.
      send_item(8'hFF, 1'b1, 1'b1);
      send_text("OK\015");
      // Shares its start with ERROR but reports the number kind.
      send_text("ERROR+CNUM:");
      // Record cut short, then dropped by a no-record transfer.
      send_item("+", 1'b0, 1'b1);
      send_item("C", 1'b0, 1'b1);
      send_item("M", 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);

      // Random part: mostly prefixes with random tails, some cut short or
      // corrupted, some plain noise, and stray no-record transfers.
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         body.delete();
         abort_at = -1;
         if (pick < 8) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
         end else begin
            if (pick < 80) begin
               idx = $urandom_range(0, 29);
               n = tracker.text[idx].len();
               if ($urandom_range(0, 4) == 0)
                  n = $urandom_range(1, n - 1);
               for (int k = 0; k < n; k++)
                  body.push_back(tracker.text[idx][k]);
               if ($urandom_range(0, 6) == 0)
                  body[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
               // Occasional long tails push the position into saturation.
               tail_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 4);
            end else begin
               tail_len = $urandom_range(1, 8);
            end
            for (int k = 0; k < tail_len; k++)
               body.push_back(8'($urandom_range(0, 255)));
            if (body.size() > 1 && $urandom_range(0, 19) == 0)
               abort_at = $urandom_range(1, body.size() - 1);
            send_bytes(body, abort_at);
         end
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      // Leave room for any stray result.
      repeat (10) @(posedge clock);

      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
